>>> rtl/pru_pkg.sv
// Shared types and constants of the pixel replication upscaler.
// Holds status and register codes, the queue entry type and default sizes.
// No dependencies.
package pru_pkg;

	localparam int CFG_W       = 11;
	localparam int SCALE_REG_W = 4;
	localparam int PIX_W       = 8;
	localparam int IDX_W       = 2;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int DEF_MAX_SCALE  = 8;

	localparam int RESET_WIDTH  = 1024;
	localparam int RESET_HEIGHT = 1024;
	localparam int RESET_SCALE  = 1;

	localparam int QUEUE_DEPTH = 4;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_REJECT = 2'd1,
		ST_IDLE   = 2'd2
	} status_t;

	typedef enum logic [IDX_W-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_SCALE  = 2'd2
	} cfg_reg_t;

	// one classified request, waiting to be expanded into a run
	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		status_t          status;
		logic             eol;
		logic             eof;
	} job_t;

endpackage

>>> rtl/pru_if.sv
// Channel interfaces of the pixel replication upscaler: request and result.
// Depends on pru_pkg.
interface pru_in_if import pru_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             op;
	logic [PIX_W-1:0] pixel_in;

	modport source(output valid, op, pixel_in, input ready);
	modport sink(input valid, op, pixel_in, output ready);
endinterface

interface pru_out_if import pru_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_out;
	logic [1:0]       status;
	logic             last_in_run;
	logic             end_of_line;
	logic             end_of_frame;

	modport source(output valid, pixel_out, status, last_in_run, end_of_line, end_of_frame,
		input ready);
	modport sink(input valid, pixel_out, status, last_in_run, end_of_line, end_of_frame,
		output ready);
endinterface

>>> rtl/pru_front.sv
// Front end: accepts requests, keeps row/column/replay counters and the line store,
// and hands one classified job per request to the queue. Depends on pru_pkg, pru_if.
module pru_front import pru_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int MAX_SCALE  = DEF_MAX_SCALE,
	localparam int EW  = $clog2(MAX_WIDTH + 1),
	localparam int HW  = $clog2(MAX_HEIGHT + 1),
	localparam int SW  = $clog2(MAX_SCALE + 1),
	localparam int LVW = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	pru_in_if.sink         in_ch,
	input  logic [EW-1:0]  w_eff,
	input  logic [HW-1:0]  h_eff,
	input  logic [SW-1:0]  s_eff,
	input  logic [LVW-1:0] level,
	output logic           push,
	output job_t           push_job
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int LW = $clog2(MAX_SCALE);

	logic [CW-1:0] col_q, col_d;
	logic [RW-1:0] row_q, row_d;
	logic          replay_q, replay_d;
	logic [LW-1:0] line_q, line_d;
	logic [CW-1:0] rcol_q, rcol_d;

	logic [PIX_W-1:0] store_q [MAX_WIDTH];
	logic [PIX_W-1:0] rd_s1;
	logic             s1_valid;
	job_t             job_s1;
	logic             use_mem_s1;

	logic accept, store_we, use_mem;
	logic col_last, rcol_last, row_last, line_last, s_one;
	logic [RW-1:0] row_next;
	job_t job_c;

	// reserve a queue slot for the job still in flight in stage one
	assign in_ch.ready = ({1'b0, level} + (LVW+1)'(s1_valid)) < (LVW+1)'(QUEUE_DEPTH);
	assign accept      = in_ch.valid && in_ch.ready;

	assign col_last  = (EW'(col_q) + EW'(1)) >= w_eff;
	assign rcol_last = (EW'(rcol_q) + EW'(1)) >= w_eff;
	assign row_last  = (HW'(row_q) + HW'(1)) >= h_eff;
	assign line_last = (SW'(line_q) + SW'(1)) >= s_eff;
	assign s_one     = s_eff == SW'(1);
	assign row_next  = row_last ? '0 : RW'(row_q + RW'(1));

	always_comb begin
		job_c.pixel  = in_ch.pixel_in;
		job_c.status = ST_OK;
		job_c.eol    = 1'b0;
		job_c.eof    = 1'b0;
		use_mem      = 1'b0;
		store_we     = 1'b0;
		col_d        = col_q;
		row_d        = row_q;
		replay_d     = replay_q;
		line_d       = line_q;
		rcol_d       = rcol_q;
		if (in_ch.op == OP_PIXEL) begin
			if (replay_q) begin
				job_c.pixel  = '0;
				job_c.status = ST_REJECT;
			end else begin
				store_we  = 1'b1;
				job_c.eol = col_last;
				job_c.eof = col_last && s_one && row_last;
				if (col_last) begin
					col_d = '0;
					if (!s_one) begin
						replay_d = 1'b1;
						line_d   = LW'(1);
						rcol_d   = '0;
					end else begin
						row_d = row_next;
					end
				end else begin
					col_d = CW'(col_q + CW'(1));
				end
			end
		end else begin
			if (!replay_q) begin
				job_c.pixel  = '0;
				job_c.status = ST_IDLE;
			end else begin
				use_mem   = 1'b1;
				job_c.eol = rcol_last;
				job_c.eof = rcol_last && line_last && row_last;
				if (rcol_last) begin
					rcol_d = '0;
					if (line_last) begin
						replay_d = 1'b0;
						line_d   = '0;
						row_d    = row_next;
					end else begin
						line_d = LW'(SW'(line_q) + SW'(1));
					end
				end else begin
					rcol_d = CW'(rcol_q + CW'(1));
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			replay_q <= 1'b0;
			line_q   <= '0;
			rcol_q   <= '0;
			s1_valid <= 1'b0;
		end else begin
			s1_valid <= accept;
			if (accept) begin
				col_q    <= col_d;
				row_q    <= row_d;
				replay_q <= replay_d;
				line_q   <= line_d;
				rcol_q   <= rcol_d;
			end
		end
	end

	// line store: one write or one registered read per request
	always_ff @(posedge clk) begin
		if (accept && store_we) begin
			store_q[col_q] <= in_ch.pixel_in;
		end
		if (accept && use_mem) begin
			rd_s1 <= store_q[rcol_q];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1     <= job_c;
			use_mem_s1 <= use_mem;
		end
	end

	always_comb begin
		push_job = job_s1;
		if (use_mem_s1) begin
			push_job.pixel = rd_s1;
		end
	end

	assign push = s1_valid;

endmodule

>>> rtl/pru_queue.sv
// Short job queue between front and back end.
// Depends on pru_pkg.
module pru_queue import pru_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH,
	localparam int LVW  = $clog2(DEPTH + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  job_t           push_job,
	input  logic           pop,
	output job_t           head,
	output logic           empty,
	output logic [LVW-1:0] level
);

	localparam int AW = $clog2(DEPTH);

	job_t            slot_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [LVW-1:0]  level_q;

	assign head  = slot_q[rd_ptr_q];
	assign empty = level_q == '0;
	assign level = level_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr_q + AW'(1));
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr_q + AW'(1));
			end
			unique case ({push, pop})
				2'b10:   level_q <= LVW'(level_q + LVW'(1));
				2'b01:   level_q <= LVW'(level_q - LVW'(1));
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

>>> rtl/pru_back.sv
// Back end: expands the job at the queue head into a run of copies, one per
// cycle while the result port is ready. Depends on pru_pkg, pru_if.
module pru_back import pru_pkg::*; #(
	parameter int MAX_SCALE = DEF_MAX_SCALE,
	localparam int SW       = $clog2(MAX_SCALE + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [SW-1:0] s_eff,
	input  job_t          head,
	input  logic          empty,
	output logic          pop,
	pru_out_if.source     out_ch
);

	logic [SW-1:0] cnt_q;
	logic [SW-1:0] run_len;
	logic          last, fire;

	// rejected and idle requests give a single result
	assign run_len = (head.status == ST_OK) ? s_eff : SW'(1);
	assign last    = (SW'(cnt_q + SW'(1))) == run_len;
	assign fire    = out_ch.valid && out_ch.ready;
	assign pop     = fire && last;

	assign out_ch.valid        = !empty;
	assign out_ch.pixel_out    = head.pixel;
	assign out_ch.status       = head.status;
	assign out_ch.last_in_run  = last;
	assign out_ch.end_of_line  = head.eol && last;
	assign out_ch.end_of_frame = head.eof && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (fire) begin
			cnt_q <= last ? '0 : SW'(cnt_q + SW'(1));
		end
	end

endmodule

>>> rtl/pixel_replication_upscaler_unit.sv
// Pixel replication upscaler: enlarges an 8-bit image by an integer factor (1..MAX_SCALE)
// in both directions. Send source pixels in row-major order (op pixel); each one is stored
// in the line store and comes out at once as a run of scale copies. After a row ends, send
// scale-1 advance ticks per source pixel to replay the stored row once per extra output
// line. A pixel sent during replay yields one result with status reject; a tick with
// nothing to replay yields one result with status idle. Each request gives scale results
// (one for reject/idle), at one result per cycle while the result port is ready, so
// sustained throughput is set by the single result port of the back end; a request that
// gives one result sustains one per cycle. A request passes a front-end register and a
// queue slot. Up to four classified requests queue between the front end (counters and
// line store, at most one store access per request) and the back end, so input keeps
// being taken while a result waits. Program registers only while the block is idle.
// Depends on pru_pkg, pru_if, pru_front, pru_queue, pru_back.
module pixel_replication_upscaler_unit import pru_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int MAX_SCALE  = DEF_MAX_SCALE
) (
	input  logic             clk,
	input  logic             arst_n,
	pru_in_if.sink           in_ch,
	pru_out_if.source        out_ch,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0] wr_data
);

	localparam int EW  = $clog2(MAX_WIDTH + 1);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int SW  = $clog2(MAX_SCALE + 1);
	localparam int LVW = $clog2(QUEUE_DEPTH + 1);

	logic [CFG_W-1:0]       width_q, height_q;
	logic [SCALE_REG_W-1:0] scale_q;

	logic [EW-1:0]  w_eff;
	logic [HW-1:0]  h_eff;
	logic [SW-1:0]  s_eff;

	logic           push, pop, empty;
	job_t           push_job, head;
	logic [LVW-1:0] level;

	// configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(RESET_WIDTH);
			height_q <= CFG_W'(RESET_HEIGHT);
			scale_q  <= SCALE_REG_W'(RESET_SCALE);
		end else if (wr_en) begin
			unique case (cfg_reg_t'(wr_index))
				REG_WIDTH:  width_q  <= wr_data;
				REG_HEIGHT: height_q <= wr_data;
				REG_SCALE:  scale_q  <= wr_data[SCALE_REG_W-1:0];
				default:    ;
			endcase
		end
	end

	// effective sizes: zero acts as one, values above the maximum saturate
	always_comb begin
		if (width_q == '0) begin
			w_eff = EW'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w_eff = EW'(MAX_WIDTH);
		end else begin
			w_eff = EW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = HW'(1);
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(height_q);
		end
		if (scale_q == '0) begin
			s_eff = SW'(1);
		end else if (32'(scale_q) > 32'(MAX_SCALE)) begin
			s_eff = SW'(MAX_SCALE);
		end else begin
			s_eff = SW'(scale_q);
		end
	end

	// classify requests, track position, access the line store
	pru_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.MAX_SCALE (MAX_SCALE)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.w_eff   (w_eff),
		.h_eff   (h_eff),
		.s_eff   (s_eff),
		.level   (level),
		.push    (push),
		.push_job(push_job)
	);

	// hold classified jobs so each side can stall on its own
	pru_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.head    (head),
		.empty   (empty),
		.level   (level)
	);

	// expand each job into its run of copies
	pru_back #(
		.MAX_SCALE(MAX_SCALE)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.s_eff (s_eff),
		.head  (head),
		.empty (empty),
		.pop   (pop),
		.out_ch(out_ch)
	);

endmodule

>>> verif/pixel_replication_upscaler_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of pixel_replication_upscaler_unit: a directed table, then random
// phases of mostly well-formed rows with random gaps, stalls and register settings.
// Depends on pru_pkg, pru_if and the upscaler RTL.
module pixel_replication_upscaler_unit_tb;
	import pru_pkg::*;

	localparam int MAX_W           = DEF_MAX_WIDTH;
	localparam int MAX_H           = DEF_MAX_HEIGHT;
	localparam int MAX_S           = DEF_MAX_SCALE;
	localparam int RESET_CYCLES    = 12;
	localparam int DRAIN_CYCLES    = 4;
	localparam int STALL_LIMIT     = 2000;
	localparam int RANDOM_REQUESTS = 256;
	// index 3 decodes to no register; writes there must be ignored
	localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

	// one output pixel as the block should present it
	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		status_t          status;
		logic             last;
		logic             eol;
		logic             eof;
	} pix_result_t;

	typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;

	// one line of the directed table: either a register setting or a request,
	// the latter with an optional hand-written expectation
	typedef struct packed {
		row_kind_t        kind;
		logic [CFG_W-1:0] width;
		logic [CFG_W-1:0] height;
		logic [3:0]       scale;
		logic             stray;
		logic             op;
		logic [PIX_W-1:0] pix;
		logic             typed;
		pix_result_t      exp;
	} stim_row_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             wr_en;
	logic [IDX_W-1:0] wr_index;
	logic [CFG_W-1:0] wr_data;

	pru_in_if  req_ch();
	pru_out_if res_ch();

	pixel_replication_upscaler_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (req_ch),
		.out_ch  (res_ch),
		.wr_en   (wr_en),
		.wr_index(wr_index),
		.wr_data (wr_data)
	);

	always #10 clk = ~clk;

	// ---------------------------------------------------------------------------------------
	// Predictor state: shadow registers, line store and the raster counters
	// ---------------------------------------------------------------------------------------
	logic [CFG_W-1:0] cfg_width;
	logic [CFG_W-1:0] cfg_height;
	logic [3:0]       cfg_scale;
	logic [PIX_W-1:0] row_mem [0:MAX_W-1];
	int unsigned      src_col;
	int unsigned      src_row;
	int unsigned      rep_line;
	int unsigned      rep_col;
	bit               rep_active;

	pix_result_t run_buf[$];          // results of the request just accepted
	pix_result_t pending_results[$];  // results still owed by the block
	stim_row_t   stim_table[$];

	bit calm;                         // set for phases run without gaps or stalls
	int stall_left;
	int fail_count;
	int requests_sent;
	int directed_count;
	int setting_count;
	int results_checked;
	int frames_done;
	int rejected;
	int idle_ticks;

	function automatic pix_result_t mk_result(logic [PIX_W-1:0] pixel, status_t st, logic last,
		logic eol, logic eof);
		pix_result_t r;
		r.pixel  = pixel;
		r.status = st;
		r.last   = last;
		r.eol    = eol;
		r.eof    = eof;
		return r;
	endfunction

	// zero acts as one, anything above the hardware limit saturates
	function automatic int unsigned clamp_cfg(int unsigned v, int unsigned hi);
		if (v == 0)
			return 1;
		return (v > hi) ? hi : v;
	endfunction

	// a run of scale copies; only the final copy carries the line and frame marks
	function automatic void emit_copies(logic [PIX_W-1:0] pixel, int unsigned s, logic eol,
		logic eof);
		logic last;
		for (int unsigned i = 0; i < s; i++) begin
			last = (i + 1 == s);
			run_buf.push_back(mk_result(pixel, ST_OK, last, eol && last, eof && last));
		end
	endfunction

	function automatic void next_source_row();
		src_row++;
		if (src_row >= clamp_cfg(cfg_height, MAX_H))
			src_row = 0;
	endfunction

	// work out what one accepted request produces and advance the shadow state
	function automatic void predict_request(logic op, logic [PIX_W-1:0] pix);
		int unsigned w;
		int unsigned h;
		int unsigned s;
		logic        eol;
		logic        eof;
		w = clamp_cfg(cfg_width, MAX_W);
		h = clamp_cfg(cfg_height, MAX_H);
		s = clamp_cfg(cfg_scale, MAX_S);
		run_buf.delete();
		if (op == OP_PIXEL) begin
			if (rep_active) begin
				run_buf.push_back(mk_result('0, ST_REJECT, 1'b1, 1'b0, 1'b0));
			end else begin
				row_mem[src_col] = pix;
				eol = (src_col + 1 >= w);
				eof = eol && (s == 1) && (src_row + 1 >= h);
				emit_copies(pix, s, eol, eof);
				if (eol) begin
					src_col = 0;
					if (s > 1) begin
						rep_active = 1'b1;
						rep_line   = 1;
						rep_col    = 0;
					end else begin
						next_source_row();
					end
				end else begin
					src_col++;
				end
			end
		end else begin
			if (!rep_active) begin
				run_buf.push_back(mk_result('0, ST_IDLE, 1'b1, 1'b0, 1'b0));
			end else begin
				eol = (rep_col + 1 >= w);
				eof = eol && (rep_line + 1 >= s) && (src_row + 1 >= h);
				emit_copies(row_mem[rep_col], s, eol, eof);
				if (eol) begin
					rep_col = 0;
					rep_line++;
					if (rep_line >= s) begin
						rep_active = 1'b0;
						rep_line   = 0;
						next_source_row();
					end
				end else begin
					rep_col++;
				end
			end
		end
	endfunction

	function automatic int draw_wait();
		return calm ? 0 : int'($urandom_range(0, 4));
	endfunction

	function automatic void check_field(string name, logic [PIX_W-1:0] want_v,
		logic [PIX_W-1:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0h, got %0h", name, want_v, got_v);
			fail_count++;
		end
	endfunction

	// ---------------------------------------------------------------------------------------
	// Directed table builders
	// ---------------------------------------------------------------------------------------
	function automatic void tab_cfg(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, logic [3:0] s,
		logic stray);
		stim_row_t row;
		row        = '0;
		row.kind   = ROW_CFG;
		row.width  = w;
		row.height = h;
		row.scale  = s;
		row.stray  = stray;
		stim_table.push_back(row);
	endfunction

	function automatic void tab_req(logic op, logic [PIX_W-1:0] pix);
		stim_row_t row;
		row      = '0;
		row.kind = ROW_REQ;
		row.op   = op;
		row.pix  = pix;
		stim_table.push_back(row);
	endfunction

	function automatic void tab_chk(logic op, logic [PIX_W-1:0] pix, pix_result_t exp);
		stim_row_t row;
		row       = '0;
		row.kind  = ROW_REQ;
		row.op    = op;
		row.pix   = pix;
		row.typed = 1'b1;
		row.exp   = exp;
		stim_table.push_back(row);
	endfunction

	// ---------------------------------------------------------------------------------------
	// Request side
	// ---------------------------------------------------------------------------------------

	// Offer one request after a random gap and hold it until it is taken. Prediction runs
	// at the accepting edge, before any of its results can appear.
	// A typed row owes the hand-written result instead of the predicted one.
	task automatic send_request(logic op, logic [PIX_W-1:0] pix, logic typed,
		pix_result_t exp);
		int gap;
		gap = draw_wait();
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.op       <= op;
		req_ch.pixel_in <= pix;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		predict_request(op, pix);
		if (typed)
			pending_results.push_back(exp);
		else
			foreach (run_buf[i])
				pending_results.push_back(run_buf[i]);
		requests_sent++;
	endtask

	// Drop valid, wait for every owed result, then let the pipeline settle before
	// touching the registers.
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all three registers back to back, optionally followed by a write to the spare
	// index. Upper data bits of the scale write are random; only four bits are kept.
	task automatic program_regs(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, logic [3:0] s,
		logic stray);
		logic [CFG_W-5:0] junk;
		junk     = (CFG_W-4)'($urandom);
		wr_en    <= 1'b1;
		wr_index <= REG_WIDTH;
		wr_data  <= w;
		@(posedge clk);
		cfg_width = w;
		wr_index <= REG_HEIGHT;
		wr_data  <= h;
		@(posedge clk);
		cfg_height = h;
		wr_index <= REG_SCALE;
		wr_data  <= {junk, s};
		@(posedge clk);
		cfg_scale = s;
		if (stray) begin
			wr_index <= REG_SPARE;
			wr_data  <= CFG_W'($urandom);
			@(posedge clk);
		end
		wr_en <= 1'b0;
		setting_count++;
	endtask

	// ---------------------------------------------------------------------------------------
	// Result side: check every accepted result against the oldest owed one, then draw the
	// stall that precedes the next result.
	// ---------------------------------------------------------------------------------------
	always @(posedge clk) begin : result_sink
		pix_result_t want;
		int          hold;
		if (!arst_n) begin
			res_ch.ready <= 1'b1;
			stall_left   <= 0;
		end else if (res_ch.valid && res_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing owed: pixel_out %0h status %0d",
					res_ch.pixel_out, res_ch.status);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("pixel_out", want.pixel, res_ch.pixel_out);
				check_field("status", want.status, res_ch.status);
				check_field("last_in_run", want.last, res_ch.last_in_run);
				check_field("end_of_line", want.eol, res_ch.end_of_line);
				check_field("end_of_frame", want.eof, res_ch.end_of_frame);
				results_checked++;
				if (want.eof)
					frames_done++;
				if (want.status == ST_REJECT)
					rejected++;
				if (want.status == ST_IDLE)
					idle_ticks++;
			end
			hold = draw_wait();
			if (hold != 0) begin
				res_ch.ready <= 1'b0;
				stall_left   <= hold;
			end
		end else if (!res_ch.ready) begin
			// release after the drawn number of low cycles
			if (stall_left <= 1)
				res_ch.ready <= 1'b1;
			stall_left <= stall_left - 1;
		end
	end

	// ---------------------------------------------------------------------------------------
	// Watchdog: end the run if neither channel moves a request or a result for too long
	// ---------------------------------------------------------------------------------------
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$error("no handshake for %0d cycles, %0d results still owed", STALL_LIMIT,
			pending_results.size());
		$display("pixel_replication_upscaler_unit regression: fail");
		$finish;
	end

	// ---------------------------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------------------------
	initial begin : main_seq
		logic [CFG_W-1:0] w;
		logic [CFG_W-1:0] h;
		logic [3:0]       s;
		logic             op;
		logic [PIX_W-1:0] pix;
		int               phase_len;
		int               random_sent;

		// hold every input at a known value from time zero
		req_ch.valid    <= 1'b0;
		req_ch.op       <= OP_PIXEL;
		req_ch.pixel_in <= '0;
		wr_en           <= 1'b0;
		wr_index        <= REG_WIDTH;
		wr_data         <= '0;
		arst_n          <= 1'b0;
		calm            = 1'b0;
		fail_count      = 0;
		requests_sent   = 0;
		setting_count   = 0;
		results_checked = 0;
		frames_done     = 0;
		rejected        = 0;
		idle_ticks      = 0;
		random_sent     = 0;

		// shadow state after reset
		cfg_width  = RESET_WIDTH;
		cfg_height = RESET_HEIGHT;
		cfg_scale  = RESET_SCALE;
		src_col    = 0;
		src_row    = 0;
		rep_line   = 0;
		rep_col    = 0;
		rep_active = 1'b0;

		// Directed table. Reset leaves a 1024 x 1024 frame at scale one, so a tick has
		// nothing to replay and each pixel gives a single unmarked copy.
		tab_chk(OP_TICK, 8'h00, mk_result(8'h00, ST_IDLE, 1'b1, 1'b0, 1'b0));
		tab_chk(OP_PIXEL, 8'h00, mk_result(8'h00, ST_OK, 1'b1, 1'b0, 1'b0));
		tab_chk(OP_PIXEL, 8'hFF, mk_result(8'hFF, ST_OK, 1'b1, 1'b0, 1'b0));
		// zero in every register acts as one; the column sits past the new end and wraps,
		// so the next pixel closes both the line and the one-pixel frame
		tab_cfg(11'd0, 11'd0, 4'd0, 1'b1);
		tab_chk(OP_PIXEL, 8'hA5, mk_result(8'hA5, ST_OK, 1'b1, 1'b1, 1'b1));
		tab_chk(OP_TICK, 8'h00, mk_result(8'h00, ST_IDLE, 1'b1, 1'b0, 1'b0));
		// 2 x 2 frame at scale two: a pixel during replay is turned away
		tab_cfg(11'd2, 11'd2, 4'd2, 1'b0);
		tab_req(OP_PIXEL, 8'h01);
		tab_req(OP_PIXEL, 8'h80);
		tab_chk(OP_PIXEL, 8'h3C, mk_result(8'h00, ST_REJECT, 1'b1, 1'b0, 1'b0));
		tab_req(OP_TICK, 8'h00);
		tab_req(OP_TICK, 8'hFF);
		tab_req(OP_PIXEL, 8'h7F);
		tab_req(OP_PIXEL, 8'h55);
		tab_req(OP_TICK, 8'h00);
		tab_req(OP_TICK, 8'h00);
		tab_chk(OP_TICK, 8'h00, mk_result(8'h00, ST_IDLE, 1'b1, 1'b0, 1'b0));
		// oversized values saturate: width and height 1024, scale eight
		tab_cfg(11'd2047, 11'd2047, 4'd15, 1'b1);
		tab_req(OP_PIXEL, 8'hC3);
		// narrow to one pixel mid-row at full scale: the row ends at once and seven
		// ticks replay it, the last one closing the frame
		tab_cfg(11'd1, 11'd1, 4'd8, 1'b0);
		tab_req(OP_PIXEL, 8'h5A);
		repeat (MAX_S - 1) tab_req(OP_TICK, 8'h00);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table
		foreach (stim_table[i]) begin
			if (stim_table[i].kind == ROW_CFG) begin
				drain_results();
				program_regs(stim_table[i].width, stim_table[i].height,
					stim_table[i].scale, stim_table[i].stray);
			end else begin
				send_request(stim_table[i].op, stim_table[i].pix, stim_table[i].typed,
					stim_table[i].exp);
			end
		end
		directed_count = requests_sent;

		// Random phases. Each one picks a setting, then mostly follows the raster: pixels
		// while a row fills, ticks while it replays, with an odd request of the wrong
		// kind mixed in to draw rejects and idle replies.
		while (random_sent < RANDOM_REQUESTS) begin
			drain_results();
			calm = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				0:       w = 11'd0;
				1:       w = 11'd1;
				2:       w = CFG_W'($urandom_range(1024, 2047));
				3:       w = CFG_W'($urandom_range(256, 1023));
				default: w = CFG_W'($urandom_range(2, 6));
			endcase
			case ($urandom_range(0, 7))
				0:       h = 11'd0;
				1:       h = CFG_W'($urandom_range(1024, 2047));
				default: h = CFG_W'($urandom_range(1, 3));
			endcase
			s = 4'($urandom_range(0, 15));
			// never widen a row that is being replayed: its tail was never stored
			if (rep_active)
				w = cfg_width;
			program_regs(w, h, s, ($urandom_range(0, 3) == 0));
			// wide rows only get a few pixels, so most of the run stays in small frames
			if (clamp_cfg(cfg_width, MAX_W) > 16)
				phase_len = $urandom_range(3, 10);
			else
				phase_len = $urandom_range(12, 40);
			if (phase_len > RANDOM_REQUESTS - random_sent)
				phase_len = RANDOM_REQUESTS - random_sent;
			repeat (phase_len) begin
				op = rep_active ? OP_TICK : OP_PIXEL;
				if ($urandom_range(0, 7) == 0)
					op = ~op;
				case ($urandom_range(0, 7))
					0:       pix = 8'h00;
					1:       pix = 8'hFF;
					default: pix = PIX_W'($urandom);
				endcase
				send_request(op, pix, 1'b0, '0);
				random_sent++;
			end
		end

		// let the last results drain and watch for strays
		drain_results();
		repeat (DRAIN_CYCLES * 2) @(posedge clk);

		$display("covered %0d requests (%0d directed) over %0d register settings",
			requests_sent, directed_count, setting_count);
		$display("checked %0d results: %0d frame ends, %0d rejects, %0d idle replies",
			results_checked, frames_done, rejected, idle_ticks);
		if (fail_count == 0)
			$display("pixel_replication_upscaler_unit regression: pass");
		else
			$display("pixel_replication_upscaler_unit regression: fail");
		$finish;
	end

endmodule

>>> filelist.f
rtl/pru_pkg.sv
rtl/pru_if.sv
rtl/pru_front.sv
rtl/pru_queue.sv
rtl/pru_back.sv
rtl/pixel_replication_upscaler_unit.sv
verif/pixel_replication_upscaler_unit_tb.sv
